### design/assert_macros.svh
// Assertion helper macros used by half_single_float_converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, disabled during reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assert an implication on the rising clock edge, checked during reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### design/hsfc_pkg.sv
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types and constants for the binary32 / binary16 converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

   localparam logic ACT_S2H = 1'b0;
   localparam logic ACT_H2S = 1'b1;

   // Stage 1 -> stage 2 payload
   typedef struct packed {
      logic        action;
      logic        sign;
      // single to half
      logic        s_zero;    // exp == 0
      logic        s_special; // exp == 255
      logic        s_nan;
      logic        s_ovf;
      logic        s_sub;     // half subnormal range
      logic        s_under;   // flush to zero
      logic [4:0]  s_sh;      // shift amount minus 14 (0..10)
      logic [4:0]  s_ne;      // normal half exponent
      logic [23:0] s_sig;
      // half to single
      logic [4:0]  h_exp;
      logic [9:0]  h_man;
   } st1_type;

   // Stage 2 -> stage 3 payload
   typedef struct packed {
      logic        action;
      logic        sign;
      logic [14:0] h_base;    // half result before rounding
      logic        h_rnd;     // round increment
      logic [31:0] s_res;     // single result, sign bit clear
   } st2_type;

endpackage

### design/half_single_float_converter.sv
// Pipeline: three register stages (s1_ff, s2_ff, res_ff); rsp_valid rises
// when a request reaches res_ff.
// Throughput: one request per cycle; the pipeline advances whenever the
// output register is empty or being taken.
// Reset: synchronous active-high reset clears all stage valid bits.
// ----------------------------------------------------------------------------
// half_single_float_converter
// Three-stage binary32 / binary16 converter with valid and stall handshake.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module half_single_float_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_converted
);
   hsfc_pkg::st1_type dec_w, s1_ff, s1_in;
   hsfc_pkg::st2_type sh_w, s2_ff, s2_in;
   logic v1_ff, v2_ff, v3_ff;
   logic [31:0] res_ff, res_in;
   logic adv3, adv2, adv1;
   logic [14:0] hsum;

   hsfc_decode u_dec (.action(req_action), .operand(req_operand), .dec(dec_w));
   hsfc_shift  u_sh  (.d(s1_ff), .q(sh_w));

   assign adv3 = !v3_ff || !rsp_stall;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_stall = !adv1;

   always_comb begin
      s1_in = dec_w;
      s2_in = sh_w;
      hsum  = s2_ff.h_base + 15'(s2_ff.h_rnd);
      if (s2_ff.action == hsfc_pkg::ACT_S2H) res_in = {16'd0, s2_ff.sign, hsum};
      else res_in = {s2_ff.sign, s2_ff.s_res[30:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) s1_ff <= s1_in;
      if (adv2) s2_ff <= s2_in;
      if (adv3) res_ff <= res_in;
   end

   assign rsp_valid     = v3_ff;
   assign rsp_converted = res_ff;

   `ASSERT_CLK(a_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_converted), "result lost under stall")
   `ASSERT_CLK(a_flow, clock, reset, !v3_ff |-> !req_stall, "stall with empty output")
   `ASSERT_ALWAYS(a_rst, clock, reset |=> !rsp_valid, "valid after reset")
endmodule

### design/hsfc_decode.sv
// ----------------------------------------------------------------------------
// hsfc_decode
// Stage 1 logic: unpacks the operand and classifies the value.
// ----------------------------------------------------------------------------
module hsfc_decode (
   input  logic             action,
   input  logic [31:0]      operand,
   output hsfc_pkg::st1_type dec
);
   logic [7:0] exp8;
   logic [8:0] ne9; // exp - 112, signed 9-bit

   always_comb begin
      exp8 = operand[30:23];
      ne9  = {1'b0, exp8} - 9'd112;
      dec = '0;
      dec.action    = action;
      dec.sign      = (action == hsfc_pkg::ACT_S2H) ? operand[31] : operand[15];
      dec.s_zero    = (exp8 == 8'd0);
      dec.s_special = (exp8 == 8'hff);
      dec.s_nan     = (operand[22:0] != 23'd0);
      dec.s_ovf     = !ne9[8] && (ne9 >= 9'd31);
      dec.s_sub     = ne9[8] || (ne9 == 9'd0);
      // ne < -10 when exp < 102
      dec.s_under   = (exp8 < 8'd102);
      dec.s_sh      = 5'(9'd0 - ne9);  // -ne, valid for subnormal range
      dec.s_ne      = ne9[4:0];
      dec.s_sig     = {1'b1, operand[22:0]};
      dec.h_exp     = operand[14:10];
      dec.h_man     = operand[9:0];
   end
endmodule

### design/hsfc_shift.sv
// ----------------------------------------------------------------------------
// hsfc_shift
// Stage 2 logic: alignment shift for half results, normalize for singles.
// ----------------------------------------------------------------------------
module hsfc_shift (
   input  hsfc_pkg::st1_type d,
   output hsfc_pkg::st2_type q
);
   logic [24:0] sh_val;
   logic [3:0]  p;
   logic [9:0]  nman;
   logic [7:0]  sexp;

   always_comb begin
      q = '0;
      q.action = d.action;
      q.sign   = d.sign;
      // single to half; shift = 14 + s_sh, round bit at shift-1
      sh_val = {d.s_sig, 1'b0} >> (5'd14 + d.s_sh);
      if (d.s_zero) begin
         q.h_base = '0;
      end else if (d.s_special) begin
         q.h_base = d.s_nan ? 15'h7e00 : 15'h7c00;
      end else if (d.s_ovf) begin
         q.h_base = 15'h7c00;
      end else if (d.s_sub) begin
         if (!d.s_under) begin
            q.h_base = sh_val[15:1];
            q.h_rnd  = sh_val[0];
         end
      end else begin
         q.h_base = {d.s_ne, d.s_sig[22:13]};
         q.h_rnd  = d.s_sig[12];
      end
      // half to single: leading one search over 10 bits
      p = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (d.h_man[i]) p = 4'(i);
      end
      nman = d.h_man << (4'd10 - p);
      sexp = 8'(p) + 8'd103;
      if (d.h_exp == 5'd31) begin
         q.s_res = {1'b0, 8'hff, d.h_man, 13'd0};
      end else if (d.h_exp == 5'd0) begin
         if (d.h_man == 10'd0) q.s_res = '0;
         else q.s_res = {1'b0, sexp, nman, 13'd0};
      end else begin
         q.s_res = {1'b0, 8'(d.h_exp) + 8'd112, d.h_man, 13'd0};
      end
   end
endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the binary32 / binary16 converter against a bit-exact predictor,
// with random idle cycles on the request side and random stalls on the
// response side.
// ----------------------------------------------------------------------------
module tb;

   typedef struct {
      logic        action;
      logic [31:0] operand;
   } conv_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = hsfc_pkg::ACT_S2H;
   logic [31:0] req_operand = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_converted;

   conv_req_type pending_reqs[$];
   logic [31:0]  expected_vals[$];
   int           mismatches = 0;
   bit           calm = 1'b0;   // long stretch with no idling and no stalls
   bit           hold = 1'b0;   // sender holds off until drained
   bit           gen_done = 1'b0;

   half_single_float_converter DUT (.*);

   always #6 clock = ~clock;

   function automatic logic [31:0] to_half(logic [31:0] x);
      logic [7:0]  e;
      logic [22:0] m;
      logic [23:0] sig;
      logic [15:0] h;
      int          ne, sh;
      e = x[30:23];
      m = x[22:0];
      h = '0;
      if (e == 8'd0) begin
         h = '0;
      end else if (e == 8'hff) begin
         h = 16'h7c00 | ((m != 0) ? 16'h0200 : 16'h0);
      end else begin
         ne = int'(e) - 112;
         if (ne >= 31) begin
            h = 16'h7c00;
         end else if (ne <= 0) begin
            if (ne >= -10) begin
               sig = {1'b1, m};
               sh = 14 - ne;
               h = 16'(sig >> sh) + 16'(sig[sh-1]);
            end
         end else begin
            h = {1'b0, 5'(ne), m[22:13]} + 16'(m[12]);
         end
      end
      return {16'h0, x[31], h[14:0]};
   endfunction

   function automatic logic [31:0] to_single(logic [15:0] v);
      logic [4:0]  e;
      logic [9:0]  m;
      logic [31:0] r;
      int          p;
      e = v[14:10];
      m = v[9:0];
      if (e == 5'd31) begin
         r = {9'h0ff, m, 13'h0};
      end else if (e == 5'd0) begin
         if (m == 0) begin
            r = '0;
         end else begin
            p = 9;
            while (!m[p]) p--;
            r = {1'b0, 8'(p + 103), 23'((32'(m) << (23 - p)) & 32'h7fffff)};
         end
      end else begin
         r = {1'b0, 8'(e + 112), m, 13'h0};
      end
      return r | {v[15], 31'h0};
   endfunction

   function automatic logic [31:0] predict_conversion(conv_req_type q);
      return (q.action == hsfc_pkg::ACT_S2H) ? to_half(q.operand)
                                             : to_single(q.operand[15:0]);
   endfunction

   task automatic push(logic act, logic [31:0] op);
      conv_req_type q;
      q.action = act;
      q.operand = op;
      pending_reqs.push_back(q);
   endtask

   function automatic logic [31:0] rand_single();
      logic [31:0] x;
      x = $urandom;
      case ($urandom_range(0, 5))
         0: x[30:23] = 8'(112 + $urandom_range(0, 30));         // half normal range
         1: x[30:23] = 8'(101 + $urandom_range(0, 12));          // subnormal / underflow edge
         2: x[30:23] = 8'(140 + $urandom_range(0, 3));           // overflow edge
         3: x[30:23] = ($urandom_range(0, 1)) ? 8'hff : 8'h00;
         4: x[22:12] = ($urandom_range(0, 1)) ? 11'h7ff : 11'h001;  // rounding carries
         default: ;
      endcase
      return x;
   endfunction

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (pending_reqs.size() != 0 && !hold && (calm || $urandom_range(0, 99) >= 14)) begin
            conv_req_type q;
            q = pending_reqs.pop_front();
            req_valid   <= 1'b1;
            req_action  <= q.action;
            req_operand <= q.operand;
            expected_vals.push_back(predict_conversion(q));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_vals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected response %h", rsp_converted);
         end else begin
            logic [31:0] exp_val;
            exp_val = expected_vals.pop_front();
            if (rsp_converted !== exp_val) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: converted expected %h got %h", exp_val, rsp_converted);
            end
         end
      end
      rsp_stall <= reset ? 1'b0 : (!calm && $urandom_range(0, 99) < 14);
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // directed
      push(hsfc_pkg::ACT_S2H, 32'h0000_0000);  push(hsfc_pkg::ACT_S2H, 32'h8000_0000);
      push(hsfc_pkg::ACT_S2H, 32'h0000_0001);  push(hsfc_pkg::ACT_S2H, 32'h7f80_0000);
      push(hsfc_pkg::ACT_S2H, 32'hff80_0000);  push(hsfc_pkg::ACT_S2H, 32'h7fc0_0001);
      push(hsfc_pkg::ACT_S2H, 32'hff80_0001);  push(hsfc_pkg::ACT_S2H, 32'h4780_0000);
      push(hsfc_pkg::ACT_S2H, 32'h477f_f000);  push(hsfc_pkg::ACT_S2H, 32'h3880_0000);
      push(hsfc_pkg::ACT_S2H, 32'h387f_f000);  push(hsfc_pkg::ACT_S2H, 32'h3380_0000);
      push(hsfc_pkg::ACT_S2H, 32'h3300_0000);  push(hsfc_pkg::ACT_S2H, 32'hb2ff_ffff);
      push(hsfc_pkg::ACT_S2H, 32'h3f80_0000);  push(hsfc_pkg::ACT_S2H, 32'h7f7f_ffff);
      push(hsfc_pkg::ACT_H2S, 32'h0000_0000);  push(hsfc_pkg::ACT_H2S, 32'hffff_8000);
      push(hsfc_pkg::ACT_H2S, 32'h0000_0001);  push(hsfc_pkg::ACT_H2S, 32'h0000_03ff);
      push(hsfc_pkg::ACT_H2S, 32'h1234_7c00);  push(hsfc_pkg::ACT_H2S, 32'h0000_fdff);
      push(hsfc_pkg::ACT_H2S, 32'h0000_7bff);  push(hsfc_pkg::ACT_H2S, 32'hffff_0400);
      wait (pending_reqs.size() == 0);
      for (int i = 0; i < 1750; i++) begin
         if (i == 400) begin
            // hold off until everything in flight has drained
            wait (pending_reqs.size() == 0);
            hold = 1'b1;
            wait (expected_vals.size() == 0);
            @(posedge clock);
            hold = 1'b0;
         end
         if (i == 900) calm = 1'b1;
         if (i == 1150) calm = 1'b0;
         if ($urandom_range(0, 1))
            push(hsfc_pkg::ACT_S2H, rand_single());
         else
            push(hsfc_pkg::ACT_H2S, $urandom);
         if (pending_reqs.size() > 32) @(posedge clock);
      end
      wait (pending_reqs.size() == 0 && expected_vals.size() == 0);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_vals.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
